FILE: design/wfir_pkg.sv
// Shared types and constants for the weighted feature item ranker.
// No dependencies.
package wfir_pkg;

  localparam int NUM_FEATURES = 7;
  localparam int VALUE_FIELDS = 4;
  localparam int FEAT_W       = 18;
  localparam int SCORE_W      = 40;
  localparam int GAIN_W       = 16;
  localparam int VAL_W        = 10;
  localparam logic [FEAT_W-1:0] FEAT_SAT = '1;

  // configuration register indexes
  localparam logic [2:0] REG_OBJ_COUNT = 3'd7;

  // one classified item between the front and back parts
  typedef struct packed {
    logic [VAL_W-1:0] wgt;
    logic [VAL_W+1:0] sum;
    logic [VAL_W-1:0] mx;
    logic [VAL_W-1:0] mn;
    logic [2:0]       n;
    logic             fin;
  } item_t;

endpackage

FILE: design/wfir_front.sv
// Front part: accepts input beats, reduces the objective values to sum, max, min.
// Depends on wfir_pkg.
module wfir_front #(
  parameter int MAX_OBJECTIVES = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [4*wfir_pkg::VAL_W-1:0]           in_vals,
  input  logic [wfir_pkg::VAL_W-1:0]             in_wgt,
  input  logic                                   in_fin,
  input  logic [2:0]                             obj_count,
  output logic                                   q_valid,
  input  logic                                   q_ready,
  output wfir_pkg::item_t                        q_item
);
  localparam int LIM = (MAX_OBJECTIVES < 4) ? MAX_OBJECTIVES : 4;

  wfir_pkg::item_t item_r, cls;
  logic            vld_r;
  logic [2:0]      n;
  logic [9:0]      v;

  always_comb begin
    n = obj_count;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(LIM)) n = 3'(LIM);
    cls.wgt = in_wgt;
    cls.n   = n;
    cls.fin = in_fin;
    cls.sum = '0;
    cls.mx  = '0;
    cls.mn  = '0;
    for (int j = 0; j < 4; j++) begin
      v = in_vals[j*10 +: 10];
      if (3'(j) < n) begin
        cls.sum = cls.sum + 12'(v);
        if (j == 0 || v > cls.mx) cls.mx = v;
        if (j == 0 || v < cls.mn) cls.mn = v;
      end
    end
  end

  assign in_tready = !vld_r || q_ready;
  assign q_valid   = vld_r;
  assign q_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) item_r <= cls;
  end
endmodule

FILE: design/wfir_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module wfir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/wfir_back.sv
// Back part: divides, scores, sorted-inserts into the stores and emits the order.
// Depends on wfir_pkg and wfir_ram.
module wfir_back #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_valid,
  output logic                                          q_ready,
  input  wfir_pkg::item_t                               q_item,
  input  logic [wfir_pkg::NUM_FEATURES*16-1:0]          gains,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [47:0]                                   out_tdata,
  output logic                                          out_tlast
);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = AW + 1;
  localparam int DIVS = 3;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DIV   = 8'b00000010,
    S_MAC   = 8'b00000100,
    S_SRCH  = 8'b00001000,
    S_SHIFT = 8'b00010000,
    S_PUT   = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_OUT   = 8'b10000000
  } st_t;

  st_t st_r;
  wfir_pkg::item_t it_r;
  logic [CW-1:0] cnt_r, pos_r, ptr_r;
  // divider: restoring, one quotient bit per cycle
  logic [19:0] num_r, rem_r;
  logic [12:0] den_r;
  logic [19:0] quo_r;
  logic [4:0]  bit_r;
  logic [1:0]  dsel_r;
  logic [17:0] q_avg_r, q_apw_r, q_mx_r, q_mn_r;
  logic [2:0]  fi_r;
  logic signed [47:0] acc_r;
  logic signed [34:0] prod_r;
  logic        prod_v_r;
  logic signed [39:0] score_r;
  logic [39:0] sc_rd;
  logic [5:0]  ix_rd;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [39:0] wsc;
  logic [5:0]  wix;
  logic [5:0]  ix_hold_r;
  logic [39:0] sc_hold_r;
  logic        rd_pend_r;
  logic [47:0] odata_r;
  logic        olast_r, ovld_r;
  logic [20:0] trial;
  logic [17:0] feat;
  logic [17:0] qsat;

  wfir_ram #(.WIDTH(40), .DEPTH(MAX_ITEMS)) u_sc (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wsc), .raddr(raddr), .rdata(sc_rd));
  wfir_ram #(.WIDTH(6), .DEPTH(MAX_ITEMS)) u_ix (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wix), .raddr(raddr), .rdata(ix_rd));

  assign q_ready = (st_r == S_IDLE);
  assign trial = {rem_r, num_r[19]} - {8'd0, den_r};
  assign qsat = (quo_r > 20'(wfir_pkg::FEAT_SAT)) ? wfir_pkg::FEAT_SAT : quo_r[17:0];

  always_comb begin
    case (fi_r)
      3'd0:    feat = {it_r.wgt, 8'd0};
      3'd1:    feat = q_avg_r;
      3'd2:    feat = {it_r.mx, 8'd0};
      3'd3:    feat = {it_r.mn, 8'd0};
      3'd4:    feat = q_apw_r;
      3'd5:    feat = q_mx_r;
      default: feat = q_mn_r;
    endcase
  end

  // read address: shift walks downward, search and emit walk upward
  always_comb begin
    we = 1'b0;
    waddr = pos_r[AW-1:0];
    wsc = score_r;
    wix = 6'(cnt_r);
    raddr = ptr_r[AW-1:0];
    if (st_r == S_SHIFT && rd_pend_r) begin
      we = 1'b1;
      waddr = AW'(ptr_r + 1'b1);
      wsc = sc_rd;
      wix = ix_rd;
    end else if (st_r == S_PUT) begin
      we = 1'b1;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ovld_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      if (ovld_r && out_tready && st_r != S_OUT) ovld_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          if (cnt_r == CW'(MAX_ITEMS)) begin
            if (q_item.fin) begin
              st_r <= S_EMIT; ptr_r <= '0; rd_pend_r <= 1'b0;
            end
          end else begin
            // first division: sum*256 / n (average)
            dsel_r <= 2'd0;
            num_r <= {q_item.sum, 8'd0};
            den_r <= 13'(q_item.n);
            rem_r <= '0; quo_r <= '0; bit_r <= '0;
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_r == 5'd20) begin
            // quo_r is complete, load the next division
            rem_r <= '0; quo_r <= '0; bit_r <= '0;
            case (dsel_r)
              2'd0: begin
                q_avg_r <= qsat;
                dsel_r <= 2'd1;
                num_r <= {it_r.sum, 8'd0};
                den_r <= 13'(it_r.n) * 13'(it_r.wgt);
              end
              2'd1: begin
                q_apw_r <= qsat;
                dsel_r <= 2'd2;
                num_r <= {2'd0, it_r.mx, 8'd0};
                den_r <= 13'(it_r.wgt);
              end
              2'd2: begin
                q_mx_r <= qsat;
                dsel_r <= 2'd3;
                num_r <= {2'd0, it_r.mn, 8'd0};
                den_r <= 13'(it_r.wgt);
              end
              default: begin
                q_mn_r <= qsat;
                st_r <= S_MAC;
                fi_r <= '0; acc_r <= '0; prod_v_r <= 1'b0;
              end
            endcase
          end else begin
            if (!trial[20]) begin
              rem_r <= trial[19:0];
              quo_r <= {quo_r[18:0], 1'b1};
            end else begin
              rem_r <= {rem_r[18:0], num_r[19]};
              quo_r <= {quo_r[18:0], 1'b0};
            end
            num_r <= {num_r[18:0], 1'b0};
            bit_r <= bit_r + 5'd1;
          end
        end
        S_MAC: begin
          prod_v_r <= (fi_r != 3'(DIVS + 4));
          if (fi_r != 3'(DIVS + 4)) begin
            prod_r <= $signed(gains[fi_r*16 +: 16]) * $signed({1'b0, feat});
            fi_r <= fi_r + 3'd1;
          end
          if (prod_v_r) acc_r <= acc_r + 48'(prod_r);
          if (!prod_v_r && fi_r == 3'(DIVS + 4)) begin
            if (acc_r > 48'sd549755813887) score_r <= 40'sh7FFFFFFFFF;
            else if (acc_r < -48'sd549755813888) score_r <= 40'sh8000000000;
            else score_r <= acc_r[39:0];
            st_r <= S_SRCH; ptr_r <= '0; rd_pend_r <= 1'b0;
          end
        end
        S_SRCH: begin
          // linear search for first entry with score below the new one
          if (rd_pend_r && $signed(sc_rd) < score_r) begin
            pos_r <= ptr_r - 1'b1;
            ptr_r <= cnt_r - 1'b1;
            rd_pend_r <= 1'b0;
            st_r <= (cnt_r == ptr_r - 1'b1) ? S_PUT : S_SHIFT;
          end else if (ptr_r == cnt_r && (rd_pend_r || cnt_r == '0)) begin
            pos_r <= cnt_r; st_r <= S_PUT; rd_pend_r <= 1'b0;
          end else if (ptr_r != cnt_r) begin
            rd_pend_r <= 1'b1;
            ptr_r <= ptr_r + 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
          end
        end
        S_SHIFT: begin
          // move entries pos..cnt-1 up by one, top down
          if (rd_pend_r && ptr_r == pos_r) begin
            st_r <= S_PUT; rd_pend_r <= 1'b0;
          end else if (rd_pend_r) begin
            ptr_r <= ptr_r - 1'b1; rd_pend_r <= 1'b0;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_PUT: begin
          cnt_r <= cnt_r + 1'b1;
          if (it_r.fin) begin
            st_r <= S_EMIT; ptr_r <= '0; rd_pend_r <= 1'b0;
          end else st_r <= S_IDLE;
        end
        S_EMIT: begin
          if (cnt_r == '0) st_r <= S_IDLE;
          else if (rd_pend_r) begin
            ix_hold_r <= ix_rd; sc_hold_r <= sc_rd; st_r <= S_OUT;
          end else rd_pend_r <= 1'b1;
        end
        S_OUT: if (!ovld_r || out_tready) begin
          ovld_r <= 1'b1;
          odata_r <= {2'd0, sc_hold_r, ix_hold_r};
          olast_r <= (ptr_r + 1'b1 == cnt_r);
          rd_pend_r <= 1'b0;
          if (ptr_r + 1'b1 == cnt_r) begin
            cnt_r <= '0; st_r <= S_IDLE;
          end else begin
            ptr_r <= ptr_r + 1'b1; st_r <= S_EMIT;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/weighted_feature_item_ranker_core.sv
// Top level of the weighted feature item ranker.
// Depends on wfir_pkg, wfir_front, wfir_back (and wfir_ram below it).
//
// Input channel in_*: one knapsack item per beat. After each item the block
// divides (four restoring divisions), scores with one 16x19 multiply per
// feature, then inserts the item into a sorted store with a linear search
// and a shift of the lower ranked entries over the store RAM. The one-deep
// front register lets one further item wait while the back works.
// On a beat with tlast set the whole order is sent on out_*, best score first,
// one beat per stored item, out_tlast on the lowest ranked.
// Items beyond MAX_ITEMS in a set are dropped. A stalled receiver holds the
// output register and the sequencer waits. Reset (rst_n low, synchronous)
// empties the set, clears gains to zero and sets the objective count to one.
module weighted_feature_item_ranker_core #(
  parameter int MAX_ITEMS      = 64,
  parameter int MAX_OBJECTIVES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // item_weight, value_0, value_1, value_2, value_3
  input  logic        in_tlast,   // final_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // item_index, item_score
  output logic        out_tlast,  // last_of_order
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  logic [wfir_pkg::NUM_FEATURES*16-1:0] gains_r;
  logic [2:0]       obj_r;
  logic             q_valid, q_ready;
  wfir_pkg::item_t  q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
      obj_r   <= 3'd1;
    end else if (cfg_we) begin
      if (cfg_index == wfir_pkg::REG_OBJ_COUNT) obj_r <= cfg_wdata[2:0];
      else gains_r[cfg_index*16 +: 16] <= cfg_wdata;
    end
  end

  wfir_front #(.MAX_OBJECTIVES(MAX_OBJECTIVES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_vals(in_tdata[49:10]), .in_wgt(in_tdata[9:0]), .in_fin(in_tlast),
    .obj_count(obj_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

  wfir_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .gains(gains_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast));
endmodule

FILE: tb/tb_ranker_checker.sv
// Scoreboard for the weighted feature item ranker: watches the config port and
// both streams, predicts the ranked order and compares every output beat.
// Depends on wfir_pkg.
module tb_ranker_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          rank_pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  STORE_DEPTH = 64;
  localparam longint SAT_HI = 64'sd549755813887;
  localparam longint SAT_LO = -64'sd549755813888;

  typedef struct {
    logic [5:0]          idx;
    logic signed [39:0]  score;
    logic                last;
  } rank_beat_t;

  logic signed [wfir_pkg::GAIN_W-1:0] gain_q[wfir_pkg::NUM_FEATURES];
  logic [2:0]               obj_count;
  longint                   sorted_scores[$];
  int                       sorted_ids[$];
  rank_beat_t               rank_queue[$];

  assign rank_pending = rank_queue.size();

  function automatic longint capped_div(longint num, longint den);
    longint q;
    if (den == 0) return longint'(wfir_pkg::FEAT_SAT);
    q = num / den;
    return (q > longint'(wfir_pkg::FEAT_SAT)) ? longint'(wfir_pkg::FEAT_SAT) : q;
  endfunction

  function automatic longint item_score(logic [55:0] d);
    longint w, sum, mx, mn, v, acc;
    longint feat[wfir_pkg::NUM_FEATURES];
    int n;
    n = (obj_count == 0) ? 1 :
        ((obj_count > wfir_pkg::VALUE_FIELDS) ? wfir_pkg::VALUE_FIELDS : obj_count);
    w = d[9:0];
    sum = 0; mx = 0; mn = 0;
    for (int j = 0; j < n; j++) begin
      v = d[10*(j+1) +: 10];
      sum += v;
      if (j == 0 || v > mx) mx = v;
      if (j == 0 || v < mn) mn = v;
    end
    feat[0] = w * 256;
    feat[1] = (sum * 256) / n;
    feat[2] = mx * 256;
    feat[3] = mn * 256;
    feat[4] = capped_div(sum * 256, n * w);
    feat[5] = capped_div(mx * 256, w);
    feat[6] = capped_div(mn * 256, w);
    acc = 0;
    for (int j = 0; j < wfir_pkg::NUM_FEATURES; j++) acc += longint'(gain_q[j]) * feat[j];
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return acc;
  endfunction

  always @(posedge clk) begin
    longint s;
    int pos;
    rank_beat_t got, want;
    if (!rst_n) begin
      foreach (gain_q[j]) gain_q[j] = '0;
      obj_count = 3'd1;
      sorted_scores.delete();
      sorted_ids.delete();
      rank_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == wfir_pkg::REG_OBJ_COUNT) obj_count = cfg_wdata[2:0];
        else gain_q[cfg_index] = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (sorted_scores.size() < STORE_DEPTH) begin
          s = item_score(in_tdata);
          pos = 0;
          while (pos < sorted_scores.size() && sorted_scores[pos] >= s) pos++;
          sorted_ids.insert(pos, sorted_scores.size());
          sorted_scores.insert(pos, s);
        end
        if (in_tlast) begin
          foreach (sorted_scores[k]) begin
            want.idx   = 6'(sorted_ids[k]);
            want.score = 40'(sorted_scores[k]);
            want.last  = (k == sorted_scores.size() - 1);
            rank_queue = {rank_queue, want};
          end
          sorted_scores.delete();
          sorted_ids.delete();
        end
      end
      if (out_tvalid && out_tready) begin
        got.idx   = out_tdata[5:0];
        got.score = out_tdata[45:6];
        got.last  = out_tlast;
        if (rank_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output beat idx=%0d score=%0d", got.idx, got.score);
        end else begin
          want = rank_queue.pop_front();
          if (got.idx !== want.idx || got.score !== want.score || got.last !== want.last ||
              out_tdata[47:46] !== 2'b00) begin
            fail_count++;
            if (fail_count <= 10)
              $display("rank mismatch: exp idx=%0d score=%0d last=%0b got idx=%0d score=%0d last=%0b",
                       want.idx, want.score, want.last, got.idx, got.score, got.last);
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

FILE: tb/tb_top.sv
// Top of the ranker testbench: clock, reset, config writes and item stimulus.
// Depends on wfir_pkg, weighted_feature_item_ranker_core and tb_ranker_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  int          rank_pending;
  int          fail_count;
  bit          stalls_on = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  weighted_feature_item_ranker_core i_dut (.*);

  tb_ranker_checker i_chk (.*);

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall before each beat
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = stalls_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_item(input logic [9:0] w, input logic [9:0] v0, input logic [9:0] v1,
                           input logic [9:0] v2, input logic [9:0] v3, input logic fin);
    int gap;
    gap = stalls_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {6'd0, v3, v2, v1, v0, w};
    in_tlast = fin;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // block is idle once the order is out; extra cycles cover an item in flight
  task automatic drain();
    in_tvalid = 1'b0;
    while (rank_pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic logic [9:0] rand_weight();
    case ($urandom_range(0, 19))
      0:       return 10'd0;
      1:       return 10'($urandom_range(1001, 1023));
      default: return 10'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic random_set(input int count);
    for (int i = 0; i < count; i++)
      send_item(rand_weight(), 10'($urandom), 10'($urandom), 10'($urandom),
                10'($urandom), i == count - 1);
  endtask

  task automatic random_gains();
    for (int g = 0; g < wfir_pkg::NUM_FEATURES; g++) begin
      case ($urandom_range(0, 5))
        0:       write_reg(3'(g), 16'h7fff);
        1:       write_reg(3'(g), 16'h8000);
        2:       write_reg(3'(g), 16'h0000);
        default: write_reg(3'(g), 16'($urandom));
      endcase
    end
    write_reg(wfir_pkg::REG_OBJ_COUNT, 16'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset gains: every score is zero, order must follow arrival
    send_item(10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0);
    send_item(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0);
    send_item(10'd500, 10'd7, 10'd9, 10'd3, 10'd1, 1'b1);
    drain();

    // largest positive gains, four objectives, zero weight included
    for (int g = 0; g < wfir_pkg::NUM_FEATURES; g++) write_reg(3'(g), 16'h7fff);
    write_reg(wfir_pkg::REG_OBJ_COUNT, 16'd4);
    send_item(10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0);
    send_item(10'd1, 10'd1023, 10'd0, 10'd512, 10'd1, 1'b0);
    send_item(10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0);
    send_item(10'd1000, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 1'b1);
    drain();

    // most negative gains, objective count zero
    for (int g = 0; g < wfir_pkg::NUM_FEATURES; g++) write_reg(3'(g), 16'h8000);
    write_reg(wfir_pkg::REG_OBJ_COUNT, 16'd0);
    send_item(10'd0, 10'd1023, 10'd5, 10'd5, 10'd5, 1'b0);
    send_item(10'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0);
    send_item(10'd2, 10'd1, 10'd1023, 10'd0, 10'd0, 1'b1);
    drain();

    // single item set, objective count beyond the value fields
    write_reg(wfir_pkg::REG_OBJ_COUNT, 16'd7);
    send_item(10'd3, 10'd1, 10'd2, 10'd1023, 10'd4, 1'b1);
    drain();

    // full store plus overflow items, dropped ones must not appear
    random_gains();
    random_set(70);
    drain();

    for (int s = 0; s < 23; s++) begin
      stalls_on = (s % 4 != 3);
      random_gains();
      random_set($urandom_range(1, 12));
      drain();
    end

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
design/wfir_pkg.sv
design/wfir_front.sv
design/wfir_ram.sv
design/wfir_back.sv
design/weighted_feature_item_ranker_core.sv
tb/tb_ranker_checker.sv
tb/tb_top.sv
